>>> hw/rtl/sacn_pkg.sv
// sacn_pkg: item types, field widths and opcodes of the set-associative nru cache
// no dependencies; imported by set_assoc_cache_nru_core
`default_nettype none

package sacn_pkg;

  localparam int ADDR_W = 48;
  localparam int WORD_W = 64;
  localparam int WIDX_W = 3;
  localparam int BYTE_W = 3;  // byte offset bits inside a 64-bit word

  typedef enum logic [1:0] {
    OP_ACCESS = 2'd0,
    OP_INSERT = 2'd1,
    OP_CLEAR  = 2'd2,
    OP_RSVD   = 2'd3
  } opcode_t;

  typedef struct packed {
    logic [1:0]        opcode;
    logic [ADDR_W-1:0] address;
    logic              read_enable;
    logic              write_enable;
    logic [WORD_W-1:0] data_word;
    logic [WIDX_W-1:0] word_index;
  } in_item_t;

  typedef struct packed {
    logic              hit;
    logic [WORD_W-1:0] rd_word;
    logic              writeback_needed;
    logic [ADDR_W-1:0] evict_address;
    logic [WORD_W-1:0] evict_word;
    logic              run_last;
  } out_item_t;

endpackage

`default_nettype wire

>>> hw/rtl/set_assoc_cache_nru_core.sv
// set_assoc_cache_nru_core: write-back set-associative cache with nru replacement
// depends on sacn_pkg (item types, opcodes)
//
// usage: one input channel (in_valid/in_stall/in_data) takes access, insert-word
// and clear items; one result channel (out_valid/out_stall/out_data) returns
// results. an access gives one result, the last insert word gives one result
// (clean victim) or LINE_WORDS results (dirty victim, words in order), other
// insert words and clears give none. opcode 3 is dropped.
// an access result is registered in S_ACC, after the S_TAG lookup; each
// install result is registered in S_INSW, after the S_INS word swap; any
// result waits while the result side stalls.
// one item at a time: an access passes S_TAG and S_ACC, an install S_TAG
// and then S_INS and S_INSW once per line word, a clear S_RCLR over all
// sets; a non-final insert word is only staged. the set metadata memory
// (read, compare, write back) has separate read and write ports; the data
// memory port, one word a cycle at one shared address, serves installs.
// reset: a sweep over the NUM_SETS rows zeroes valid, reference and dirty bits;
// in_stall is high during it.
// stall: a finished result waits in the output register while the next item
// is accepted; the core waits only to load a new result into a still-occupied
// output register. NUM_SETS and LINE_WORDS must be powers of two (not checked).
`default_nettype none

module set_assoc_cache_nru_core
  import sacn_pkg::*;
#(
  parameter int NUM_SETS   = 256,
  parameter int NUM_WAYS   = 4,
  parameter int LINE_WORDS = 8
) (
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire logic      in_valid,
  output      logic      in_stall,
  input  wire in_item_t  in_data,
  output      logic      out_valid,
  input  wire logic      out_stall,
  output      out_item_t out_data
);

  localparam int SET_W  = $clog2(NUM_SETS);
  localparam int WAY_W  = $clog2(NUM_WAYS);
  localparam int OFF_W  = $clog2(LINE_WORDS);
  localparam int TAG_W  = ADDR_W - BYTE_W - OFF_W - SET_W;
  localparam int DA_W   = SET_W + WAY_W + OFF_W;
  localparam int DDEPTH = NUM_SETS * NUM_WAYS * LINE_WORDS;
  localparam int IX_W   = (OFF_W > WIDX_W) ? OFF_W : WIDX_W;
  localparam int CNT_W  = SET_W + 1;

  // one metadata row per set
  typedef struct packed {
    logic [NUM_WAYS-1:0]            valid;
    logic [NUM_WAYS-1:0]            refb;
    logic [NUM_WAYS-1:0]            dirty;
    logic [NUM_WAYS-1:0][TAG_W-1:0] tag;
  } meta_row_t;

  typedef enum logic [2:0] {
    S_INIT, S_IDLE, S_RCLR, S_TAG, S_ACC, S_INS, S_INSW
  } state_t;

  // memories
  meta_row_t         meta_mem [NUM_SETS];
  logic [WORD_W-1:0] data_mem [DDEPTH];
  logic [WORD_W-1:0] stage_r  [LINE_WORDS];

  meta_row_t         meta_rd_r;
  logic [WORD_W-1:0] dm_rd_r;

  // control and item registers
  state_t            state_r,  state_nxt;
  in_item_t          item_r;
  logic [CNT_W-1:0]  cnt_r,    cnt_nxt;
  logic [OFF_W-1:0]  k_r,      k_nxt;
  logic [WAY_W-1:0]  way_r,    way_nxt;
  logic              hit_r,    hit_nxt;
  logic              vdirty_r, vdirty_nxt;
  logic [TAG_W-1:0]  vtag_r,   vtag_nxt;
  out_item_t         out_r,    out_nxt;
  logic              out_valid_r;
  logic              out_load;

  // memory ports
  logic              mm_re, mm_we;
  logic [SET_W-1:0]  mm_raddr, mm_waddr;
  meta_row_t         mm_wdata;
  logic              dm_re, dm_we;
  logic [DA_W-1:0]   dm_addr;
  logic [WORD_W-1:0] dm_wdata;

  // field split of the incoming and the held item
  logic [IX_W-1:0]   in_widx;
  logic [OFF_W-1:0]  in_stg_idx;
  logic              in_last_word;
  logic [SET_W-1:0]  in_set, it_set;
  logic [OFF_W-1:0]  it_word;
  logic [TAG_W-1:0]  it_tag;

  // lookup results
  logic              lk_hit;
  logic [WAY_W-1:0]  lk_way;
  logic [WAY_W-1:0]  vic_way;
  logic              out_free;

  assign in_widx      = IX_W'(in_data.word_index);
  assign in_stg_idx   = in_widx[OFF_W-1:0];
  assign in_last_word = (in_widx == IX_W'(LINE_WORDS - 1));
  assign in_set       = in_data.address[BYTE_W+OFF_W +: SET_W];
  assign it_set       = item_r.address[BYTE_W+OFF_W +: SET_W];
  assign it_word      = item_r.address[BYTE_W +: OFF_W];
  assign it_tag       = item_r.address[ADDR_W-1 -: TAG_W];

  assign in_stall  = (state_r != S_IDLE);
  assign out_valid = out_valid_r;
  assign out_data  = out_r;
  assign out_free  = !out_valid_r || !out_stall;

  // hit search: lowest valid way with a matching tag
  always_comb begin
    lk_hit = 1'b0;
    lk_way = '0;
    for (int w = NUM_WAYS - 1; w >= 0; w--) begin
      if (meta_rd_r.valid[w] && (meta_rd_r.tag[w] == it_tag)) begin
        lk_hit = 1'b1;
        lk_way = WAY_W'(w);
      end
    end
  end

  // victim: first invalid, else first r0d0, r0d1, r1d0, else way 0
  always_comb begin
    logic             f_inv, f_00, f_01, f_10;
    logic [WAY_W-1:0] w_inv, w_00, w_01, w_10;
    f_inv = 1'b0; f_00 = 1'b0; f_01 = 1'b0; f_10 = 1'b0;
    w_inv = '0;   w_00 = '0;   w_01 = '0;   w_10 = '0;
    for (int w = NUM_WAYS - 1; w >= 0; w--) begin
      if (!meta_rd_r.valid[w]) begin
        f_inv = 1'b1; w_inv = WAY_W'(w);
      end
      if (!meta_rd_r.refb[w] && !meta_rd_r.dirty[w]) begin
        f_00 = 1'b1; w_00 = WAY_W'(w);
      end
      if (!meta_rd_r.refb[w] && meta_rd_r.dirty[w]) begin
        f_01 = 1'b1; w_01 = WAY_W'(w);
      end
      if (meta_rd_r.refb[w] && !meta_rd_r.dirty[w]) begin
        f_10 = 1'b1; w_10 = WAY_W'(w);
      end
    end
    priority if (f_inv) vic_way = w_inv;
    else if (f_00)      vic_way = w_00;
    else if (f_01)      vic_way = w_01;
    else if (f_10)      vic_way = w_10;
    else                vic_way = '0;
  end

  // sequencer
  always_comb begin
    state_nxt  = state_r;
    cnt_nxt    = cnt_r;
    k_nxt      = k_r;
    way_nxt    = way_r;
    hit_nxt    = hit_r;
    vdirty_nxt = vdirty_r;
    vtag_nxt   = vtag_r;
    out_nxt    = out_r;
    out_load   = 1'b0;
    mm_re      = 1'b0;
    mm_we      = 1'b0;
    mm_raddr   = in_set;
    mm_waddr   = it_set;
    mm_wdata   = meta_rd_r;
    dm_re      = 1'b0;
    dm_we      = 1'b0;
    dm_addr    = {it_set, way_r, k_r};
    dm_wdata   = stage_r[k_r];

    unique case (state_r)
      S_INIT: begin
        mm_we    = 1'b1;
        mm_waddr = cnt_r[SET_W-1:0];
        mm_wdata = '0;
        cnt_nxt  = cnt_r + 1'b1;
        if (cnt_r == CNT_W'(NUM_SETS - 1)) begin
          state_nxt = S_IDLE;
        end
      end

      S_IDLE: begin
        cnt_nxt = '0;
        k_nxt   = '0;
        if (in_valid) begin
          unique case (opcode_t'(in_data.opcode))
            OP_ACCESS: begin
              mm_re     = 1'b1;
              state_nxt = S_TAG;
            end
            OP_INSERT: begin
              if (in_last_word) begin
                mm_re     = 1'b1;
                state_nxt = S_TAG;
              end
            end
            OP_CLEAR: state_nxt = S_RCLR;
            OP_RSVD:  state_nxt = S_IDLE;
            default:  state_nxt = S_IDLE;
          endcase
        end
      end

      // read row cnt, write back row cnt-1 with reference bits cleared
      S_RCLR: begin
        mm_raddr = cnt_r[SET_W-1:0];
        mm_re    = (cnt_r != CNT_W'(NUM_SETS));
        mm_we    = (cnt_r != '0);
        mm_waddr = SET_W'(cnt_r - 1'b1);
        mm_wdata = meta_rd_r;
        mm_wdata.refb = '0;
        cnt_nxt  = cnt_r + 1'b1;
        if (cnt_r == CNT_W'(NUM_SETS)) begin
          state_nxt = S_IDLE;
        end
      end

      S_TAG: begin
        mm_wdata = meta_rd_r;
        if (opcode_t'(item_r.opcode) == OP_ACCESS) begin
          hit_nxt = lk_hit;
          way_nxt = lk_way;
          dm_addr = {it_set, lk_way, it_word};
          dm_re   = 1'b1;
          dm_wdata = item_r.data_word;
          if (lk_hit) begin
            mm_we = 1'b1;
            mm_wdata.refb[lk_way] = 1'b1;
            if (item_r.write_enable) begin
              mm_wdata.dirty[lk_way] = 1'b1;
              dm_we = 1'b1;
            end
          end
          state_nxt = S_ACC;
        end else begin
          way_nxt    = vic_way;
          vdirty_nxt = meta_rd_r.valid[vic_way] && meta_rd_r.dirty[vic_way];
          vtag_nxt   = meta_rd_r.tag[vic_way];
          mm_we      = 1'b1;
          mm_wdata.valid[vic_way] = 1'b1;
          mm_wdata.refb[vic_way]  = 1'b0;
          mm_wdata.dirty[vic_way] = 1'b0;
          mm_wdata.tag[vic_way]   = it_tag;
          k_nxt      = '0;
          state_nxt  = S_INS;
        end
      end

      S_ACC: begin
        if (out_free) begin
          out_load = 1'b1;
          out_nxt  = '0;
          out_nxt.hit     = hit_r;
          out_nxt.rd_word = (hit_r && item_r.read_enable) ? dm_rd_r : '0;
          out_nxt.run_last  = 1'b1;
          state_nxt = S_IDLE;
        end
      end

      // old word k comes out while the staged word k goes in
      S_INS: begin
        dm_addr   = {it_set, way_r, k_r};
        dm_re     = 1'b1;
        dm_we     = 1'b1;
        dm_wdata  = stage_r[k_r];
        state_nxt = S_INSW;
      end

      S_INSW: begin
        if (vdirty_r) begin
          if (out_free) begin
            out_load = 1'b1;
            out_nxt  = '0;
            out_nxt.writeback_needed = 1'b1;
            out_nxt.evict_address    = {vtag_r, it_set, {(OFF_W + BYTE_W){1'b0}}};
            out_nxt.evict_word       = dm_rd_r;
            out_nxt.run_last         = (k_r == OFF_W'(LINE_WORDS - 1));
            k_nxt     = k_r + 1'b1;
            state_nxt = (k_r == OFF_W'(LINE_WORDS - 1)) ? S_IDLE : S_INS;
          end
        end else if (k_r == OFF_W'(LINE_WORDS - 1)) begin
          if (out_free) begin
            out_load = 1'b1;
            out_nxt  = '0;
            out_nxt.run_last = 1'b1;
            state_nxt = S_IDLE;
          end
        end else begin
          k_nxt     = k_r + 1'b1;
          state_nxt = S_INS;
        end
      end

      default: state_nxt = S_IDLE;
    endcase
  end

  // metadata memory
  always_ff @(posedge clk) begin
    if (mm_we) meta_mem[mm_waddr] <= mm_wdata;
    if (mm_re) meta_rd_r <= meta_mem[mm_raddr];
  end

  // line data memory, read-before-write on a shared address
  always_ff @(posedge clk) begin
    if (dm_we) data_mem[dm_addr] <= dm_wdata;
    if (dm_re) dm_rd_r <= data_mem[dm_addr];
  end

  // insert staging
  always_ff @(posedge clk) begin
    if ((state_r == S_IDLE) && in_valid &&
        (opcode_t'(in_data.opcode) == OP_INSERT)) begin
      stage_r[in_stg_idx] <= in_data.data_word;
    end
  end

  // state and registered outputs
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_INIT;
      cnt_r       <= '0;
      k_r         <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
      k_r     <= k_nxt;
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
    if ((state_r == S_IDLE) && in_valid) begin
      item_r <= in_data;
    end
    way_r    <= way_nxt;
    hit_r    <= hit_nxt;
    vdirty_r <= vdirty_nxt;
    vtag_r   <= vtag_nxt;
    out_r    <= out_nxt;
  end

endmodule

`default_nettype wire

>>> verif/set_assoc_cache_nru_core_tb.sv
// set_assoc_cache_nru_core_tb: self-checking bench for the nru write-back cache
// drives access/insert/clear items with random idling, predicts results, checks them
// depends on sacn_pkg and set_assoc_cache_nru_core
`timescale 1ns / 1ps

module set_assoc_cache_nru_core_tb;
  import sacn_pkg::*;

  localparam int SETS = 256;
  localparam int WAYS = 4;
  localparam int LW = 8;
  localparam int LIMIT = 400000;

  logic      clk = 1'b0;
  logic      rst_n = 1'b0;
  logic      in_valid = 1'b0;
  logic      in_stall;
  in_item_t  in_data = '0;
  logic      out_valid;
  logic      out_stall = 1'b0;
  out_item_t out_data;

  set_assoc_cache_nru_core dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data)
  );

  always #5 clk = ~clk;

  // cache mirror
  bit            line_ok   [SETS*WAYS];
  bit            line_ref  [SETS*WAYS];
  bit            line_dirty[SETS*WAYS];
  logic [33:0]   line_tag  [SETS*WAYS];
  logic [63:0]   line_word [SETS*WAYS*LW];
  logic [63:0]   staged    [LW];

  in_item_t  pending_items[$];
  out_item_t expected_results[$];

  int  errors = 0;
  int  cycles = 0;
  bit  calm = 1'b0;       // last part of the run: no idling
  bit  hold_out = 1'b0;   // long receiver hold-off
  int  in_gap = 0;
  int  out_gap = 0;
  bit  in_done = 1'b0;
  bit  item_taken = 1'b0;

  // keep a few tags per set so hits and evictions actually happen
  logic [33:0] tag_pool[4] = '{34'h0, 34'h3FFFFFFFF, 34'h155555555, 34'h0AAAAAAAA};

  function automatic out_item_t mk_result(bit h, logic [63:0] rd, bit wb,
                                          logic [47:0] ea, logic [63:0] ew, bit last);
    out_item_t r;
    r.hit = h; r.rd_word = rd; r.writeback_needed = wb;
    r.evict_address = ea; r.evict_word = ew; r.run_last = last;
    return r;
  endfunction

  function automatic int choose_victim(int base);
    for (int w = 0; w < WAYS; w++) if (!line_ok[base+w]) return w;
    for (int w = 0; w < WAYS; w++) if (!line_ref[base+w] && !line_dirty[base+w]) return w;
    for (int w = 0; w < WAYS; w++) if (!line_ref[base+w] && line_dirty[base+w]) return w;
    for (int w = 0; w < WAYS; w++) if (line_ref[base+w] && !line_dirty[base+w]) return w;
    return 0;
  endfunction

  // update mirror and queue the results that one accepted item causes
  task automatic predict_cache(input in_item_t it);
    logic [33:0] tg;
    int st, wd, base, ln, v;
    bit found, dty;
    logic [47:0] ea;
    tg = it.address[47:14];
    st = it.address[13:6];
    wd = it.address[5:3];
    base = st * WAYS;
    found = 1'b0;
    case (opcode_t'(it.opcode))
      OP_ACCESS: begin
        for (int w = 0; w < WAYS; w++) begin
          ln = base + w;
          if (!found && line_ok[ln] && line_tag[ln] == tg) begin
            found = 1'b1;
            expected_results.push_back(mk_result(1'b1,
              it.read_enable ? line_word[ln*LW+wd] : 64'd0, 1'b0, '0, '0, 1'b1));
            line_ref[ln] = 1'b1;
            if (it.write_enable) begin
              line_word[ln*LW+wd] = it.data_word;
              line_dirty[ln] = 1'b1;
            end
          end
        end
        if (!found) expected_results.push_back(mk_result(1'b0, '0, 1'b0, '0, '0, 1'b1));
      end
      OP_INSERT: begin
        staged[it.word_index] = it.data_word;
        if (it.word_index == LW-1) begin
          v = choose_victim(base);
          ln = base + v;
          dty = line_ok[ln] && line_dirty[ln];
          if (dty) begin
            ea = {line_tag[ln], st[7:0], 6'd0};
            for (int k = 0; k < LW; k++)
              expected_results.push_back(mk_result(1'b0, '0, 1'b1, ea,
                line_word[ln*LW+k], k == LW-1));
          end else begin
            expected_results.push_back(mk_result(1'b0, '0, 1'b0, '0, '0, 1'b1));
          end
          line_ok[ln] = 1'b1; line_ref[ln] = 1'b0; line_dirty[ln] = 1'b0;
          line_tag[ln] = tg;
          for (int k = 0; k < LW; k++) line_word[ln*LW+k] = staged[k];
        end
      end
      OP_CLEAR: for (int i = 0; i < SETS*WAYS; i++) line_ref[i] = 1'b0;
      default: ;
    endcase
  endtask

  function automatic logic [47:0] pick_addr(bit wide);
    logic [47:0] a;
    a = {16'($urandom), $urandom};
    if (!wide) begin
      a[47:14] = tag_pool[$urandom_range(0, 3)];
      a[13:6] = 8'($urandom_range(0, 3));  // few sets so they fill up
    end
    return a;
  endfunction

  function automatic in_item_t access_item(logic [47:0] a, bit re, bit we, logic [63:0] d);
    in_item_t it;
    it.opcode = OP_ACCESS; it.address = a; it.read_enable = re;
    it.write_enable = we; it.data_word = d; it.word_index = 3'($urandom);
    return it;
  endfunction

  // a full line, optionally with reversed (out-of-order) indexes before the last
  task automatic queue_line(input logic [47:0] a, input bit scramble);
    in_item_t it;
    for (int k = 0; k < LW; k++) begin
      it.opcode = OP_INSERT;
      it.address = (k == LW-1) ? a : {16'($urandom), $urandom};
      it.read_enable = 1'($urandom); it.write_enable = 1'($urandom);
      it.data_word = {$urandom, $urandom};
      it.word_index = (scramble && k < LW-1) ? 3'(LW-2-k) : 3'(k);
      pending_items.push_back(it);
    end
  endtask

  task automatic queue_simple(input opcode_t op);
    in_item_t it;
    it = access_item(pick_addr(1'b1), 1'($urandom), 1'($urandom), {$urandom, $urandom});
    it.opcode = op;
    pending_items.push_back(it);
  endtask

  task automatic wait_drained();
    while (pending_items.size() != 0 || in_valid || expected_results.size() != 0)
      @(posedge clk);
    repeat (30) @(posedge clk);
  endtask

  // driver: next item offered at the falling edge, held while stalled
  always @(negedge clk) begin
    if (rst_n) begin
      if (!in_valid || item_taken) begin
        if (in_gap > 0) begin
          in_gap <= in_gap - 1;
          in_valid <= 1'b0;
        end else if (pending_items.size() != 0) begin
          in_data <= pending_items.pop_front();
          in_valid <= 1'b1;
          if (!calm && $urandom_range(0, 9) == 0) in_gap <= $urandom_range(1, 18);
        end else begin
          in_valid <= 1'b0;
        end
      end
      if (hold_out) out_stall <= 1'b1;
      else if (out_gap > 0) begin
        out_gap <= out_gap - 1;
        out_stall <= 1'b1;
      end else begin
        out_stall <= 1'b0;
        if (!calm && $urandom_range(0, 9) == 0) out_gap <= $urandom_range(1, 18);
      end
    end
  end

  // monitor: acceptance on both channels at the rising edge
  always @(posedge clk) begin
    out_item_t want;
    cycles <= cycles + 1;
    item_taken <= rst_n && in_valid && !in_stall;
    if (rst_n && in_valid && !in_stall) predict_cache(in_data);
    if (rst_n && out_valid && !out_stall) begin
      if (expected_results.size() == 0) begin
        errors <= errors + 1;
        if (errors < 10) $display("unexpected result %h", out_data);
      end else begin
        want = expected_results.pop_front();
        if (want.hit !== out_data.hit || want.rd_word !== out_data.rd_word ||
            want.writeback_needed !== out_data.writeback_needed ||
            want.evict_address !== out_data.evict_address ||
            want.evict_word !== out_data.evict_word || want.run_last !== out_data.run_last) begin
          errors <= errors + 1;
          if (errors < 10)
            $display({"mismatch: expected hit %b rd %h wb %b ea %h ew %h last %b,",
                      " got hit %b rd %h wb %b ea %h ew %h last %b"},
              want.hit, want.rd_word, want.writeback_needed, want.evict_address,
              want.evict_word, want.run_last, out_data.hit, out_data.rd_word,
              out_data.writeback_needed, out_data.evict_address, out_data.evict_word,
              out_data.run_last);
        end
      end
    end
    if (cycles > LIMIT) begin
      $display("Some tests failed");
      $finish;
    end
  end

  initial begin
    logic [47:0] a;
    in_item_t it;
    repeat (6) @(posedge clk);
    @(negedge clk) rst_n = 1'b1;

    // directed: miss on empty cache, extremes, reserved opcode, clear
    pending_items.push_back(access_item(48'hFFFF_FFFF_FFFF, 1'b1, 1'b1, '1));
    queue_simple(OP_RSVD);
    queue_line(48'h0, 1'b0);
    pending_items.push_back(access_item(48'h0, 1'b1, 1'b0, '0));
    pending_items.push_back(access_item(48'h38, 1'b1, 1'b1, 64'hFFFF_FFFF_FFFF_FFFF));
    pending_items.push_back(access_item(48'h38, 1'b1, 1'b0, '0));
    pending_items.push_back(access_item(48'h8, 1'b0, 1'b0, '1));
    queue_simple(OP_CLEAR);
    wait_drained();

    // fill set 0 with lines dirtied by write accesses, then keep inserting to force evictions
    for (int r = 0; r < 6; r++) begin
      a = {tag_pool[r%4] ^ 34'(r), 8'd0, 6'd0};
      queue_line(a, r[0]);
      pending_items.push_back(access_item(a | 48'h10, 1'($urandom), 1'b1,
        {$urandom, $urandom}));
    end
    queue_line(48'hFFFF_FFFF_C000, 1'b0);
    wait_drained();

    // long hold-off on the result side while items keep coming
    hold_out = 1'b1;
    for (int r = 0; r < 20; r++)
      pending_items.push_back(access_item(pick_addr(1'b0), 1'($urandom), 1'($urandom),
        {$urandom, $urandom}));
    repeat (300) @(posedge clk);
    hold_out = 1'b0;
    wait_drained();

    // random: mostly whole lines and accesses to pool addresses
    for (int r = 0; r < 30; r++) begin
      if (r == 24) begin
        wait_drained();
        calm = 1'b1;
      end
      case ($urandom_range(0, 9))
        0, 1: queue_line(pick_addr(1'b0), 1'($urandom));
        2: queue_simple($urandom_range(0, 9) == 0 ? OP_CLEAR : OP_RSVD);
        3: pending_items.push_back(access_item(pick_addr(1'b1), 1'($urandom), 1'($urandom),
             {$urandom, $urandom}));
        default: pending_items.push_back(access_item(pick_addr(1'b0), 1'($urandom),
                   1'($urandom), {$urandom, $urandom}));
      endcase
    end
    wait_drained();
    repeat (40) @(posedge clk);
    if (errors == 0) $display("All tests passed");
    else $display("Some tests failed");
    $finish;
  end

endmodule

>>> set_assoc_cache_nru_core.f
hw/rtl/sacn_pkg.sv
hw/rtl/set_assoc_cache_nru_core.sv
verif/set_assoc_cache_nru_core_tb.sv
